// ===== hdl/scmt_pkg.sv =====
// ----------------------------------------------------------------------------
// scmt_pkg
// Shared widths, codes and control types of the swap chunk map translator.
// ----------------------------------------------------------------------------
`default_nettype none

package scmt_pkg;

    // field widths
    localparam int unsigned BLOCK_W = 24;
    localparam int unsigned MIN_W   = 17;
    localparam int unsigned MAX_W   = 21;
    localparam int unsigned EIDX_W  = 5;
    localparam int unsigned CFGI_W  = 2;
    // chunk size stays below twice the largest max_chunk
    localparam int unsigned CHUNK_W = MAX_W + 1;

    // operation codes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_XLATE = 1'b1;

    // result status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_SEG  = 2'd1;
    localparam logic [1:0] ST_MAP  = 2'd2;
    localparam logic [1:0] ST_SWAP = 2'd3;

    // configuration register indexes
    localparam logic [CFGI_W-1:0] CFG_MIN_CHUNK    = 2'd0;
    localparam logic [CFGI_W-1:0] CFG_MAX_CHUNK    = 2'd1;
    localparam logic [CFGI_W-1:0] CFG_SEGMENT_SIZE = 2'd2;
    localparam logic [CFGI_W-1:0] CFG_SWAP_SIZE    = 2'd3;

    // configuration reset values
    localparam logic [MIN_W-1:0]   RST_MIN_CHUNK    = 17'd32;
    localparam logic [MAX_W-1:0]   RST_MAX_CHUNK    = 21'd1024;
    localparam logic [BLOCK_W-1:0] RST_SEGMENT_SIZE = 24'd0;
    localparam logic [BLOCK_W-1:0] RST_SWAP_SIZE    = 24'd0;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic seg_chk;
        logic walk_step;
        logic map_err;
        logic rd;
        logic bound;
        logic delta;
        logic out_load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_xlate;
        logic seg_err;
        logic map_end;
        logic walk_done;
        logic swap_err;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

// ===== hdl/scmt_ctrl.sv =====
// ----------------------------------------------------------------------------
// scmt_ctrl
// Sequencer for load and translate items: segment check, chunk walk,
// map read, swap bound check, run placement and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module scmt_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire scmt_pkg::t_sts i_sts,
    output scmt_pkg::t_cmd     o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SEG   = 3'd1;
    localparam logic [2:0] S_WALK  = 3'd2;
    localparam logic [2:0] S_RD    = 3'd3;
    localparam logic [2:0] S_BOUND = 3'd4;
    localparam logic [2:0] S_DELTA = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       accept;

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.capture = 1'b1;
                    // a translate goes to the segment check right after capture
                    n_state = i_sts.is_xlate ? S_SEG : S_DONE;
                end
            end
            S_SEG: begin
                o_cmd.seg_chk = 1'b1;
                n_state = i_sts.seg_err ? S_DONE : S_WALK;
            end
            S_WALK: begin
                // index limit wins over a finished walk
                if (i_sts.map_end) begin
                    o_cmd.map_err = 1'b1;
                    n_state = S_DONE;
                end else if (i_sts.walk_done) begin
                    n_state = S_RD;
                end else begin
                    o_cmd.walk_step = 1'b1;
                end
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state = S_BOUND;
            end
            S_BOUND: begin
                o_cmd.bound = 1'b1;
                n_state = i_sts.swap_err ? S_DONE : S_DELTA;
            end
            S_DELTA: begin
                o_cmd.delta = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                // hold until the output register frees up
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state != S_IDLE))
        else $error("scmt_ctrl: still idle after accepting an item");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK && !i_sts.map_end && !i_sts.walk_done) |=> (r_state == S_WALK))
        else $error("scmt_ctrl: walk left early");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && !i_sts.out_free) |=> (r_state == S_DONE))
        else $error("scmt_ctrl: result dropped while output busy");

endmodule

`default_nettype wire

// ===== hdl/scmt_dpath.sv =====
// ----------------------------------------------------------------------------
// scmt_dpath
// Configuration registers, chunk map memory, walk registers and the
// output register of the swap chunk map translator.
// ----------------------------------------------------------------------------
`default_nettype none

module scmt_dpath #(
    parameter int unsigned MAP_ENTRIES = 32
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    // configuration
    input  wire logic                                   i_cfg_wr,
    input  wire logic [scmt_pkg::CFGI_W-1:0]            i_cfg_index,
    input  wire logic [scmt_pkg::BLOCK_W-1:0]           i_cfg_data,
    // input item payload
    input  wire logic                                   i_op,
    input  wire logic [scmt_pkg::EIDX_W-1:0]            i_entry_index,
    input  wire logic [scmt_pkg::BLOCK_W-1:0]           i_entry_block,
    input  wire logic [scmt_pkg::BLOCK_W-1:0]           i_vs_offset,
    input  wire logic [scmt_pkg::BLOCK_W-1:0]           i_request_size,
    input  wire logic                                   i_reverse,
    // control
    input  wire scmt_pkg::t_cmd                         i_cmd,
    output scmt_pkg::t_sts                              o_sts,
    // result
    output logic                                        o_out_valid,
    input  wire logic                                   i_out_stall,
    output logic [scmt_pkg::BLOCK_W-1:0]                o_disk_base,
    output logic [scmt_pkg::BLOCK_W-1:0]                o_run_size,
    output logic [1:0]                                  o_status
);

    localparam int unsigned IDX_W = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;
    localparam int unsigned CNT_W = $clog2(MAP_ENTRIES + 1);
    localparam int unsigned BW    = scmt_pkg::BLOCK_W;
    localparam int unsigned CW    = scmt_pkg::CHUNK_W;
    localparam int unsigned EXT_W = scmt_pkg::EIDX_W + 2;

    // configuration
    logic [scmt_pkg::MIN_W-1:0] r_min_chunk;
    logic [scmt_pkg::MAX_W-1:0] r_max_chunk;
    logic [BW-1:0]              r_segment_size;
    logic [BW-1:0]              r_swap_size;

    // item state
    logic                       r_op;
    logic                       r_rev;
    logic [BW-1:0]              r_off;
    logic [BW-1:0]              r_req;
    logic [CW-1:0]              r_blk;
    logic [CNT_W-1:0]           r_idx;
    logic [1:0]                 r_status;
    logic [BW-1:0]              r_rd_data;
    logic [BW-1:0]              r_run;
    logic [BW-1:0]              r_delta;

    // output register
    logic                       r_o_valid;
    logic [BW-1:0]              r_o_base;
    logic [BW-1:0]              r_o_run;
    logic [1:0]                 r_o_status;

    logic [BW-1:0]              map_mem [MAP_ENTRIES];

    logic                       wr_ok;
    logic [IDX_W-1:0]           wr_addr;
    logic [CW-1:0]              first_blk;
    logic [BW:0]                seg_sum;
    logic [BW:0]                swap_sum;
    logic [BW-1:0]              chunk_left;
    logic [BW-1:0]              run_next;
    logic                       res_ok;

    assign wr_ok     = (EXT_W'(i_entry_index) < EXT_W'(MAP_ENTRIES));
    assign wr_addr   = IDX_W'(i_entry_index);
    // a zero min_chunk acts as one
    assign first_blk = (r_min_chunk == '0) ? CW'(1) : CW'(r_min_chunk);
    assign seg_sum   = {1'b0, r_off} + {1'b0, r_req};
    assign swap_sum  = {1'b0, r_rd_data} + (BW + 1)'(r_blk);
    assign chunk_left = BW'(r_blk) - r_off;
    assign run_next  = (r_req < chunk_left) ? r_req : chunk_left;
    assign res_ok    = (r_op == scmt_pkg::OP_XLATE) && (r_status == scmt_pkg::ST_OK);

    assign o_sts.is_xlate  = (i_op == scmt_pkg::OP_XLATE);
    assign o_sts.seg_err   = (seg_sum > {1'b0, r_segment_size});
    assign o_sts.map_end   = (r_idx == CNT_W'(MAP_ENTRIES));
    assign o_sts.walk_done = (r_off < BW'(r_blk));
    assign o_sts.swap_err  = (swap_sum > {1'b0, r_swap_size});
    assign o_sts.out_free  = !r_o_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_chunk    <= scmt_pkg::RST_MIN_CHUNK;
            r_max_chunk    <= scmt_pkg::RST_MAX_CHUNK;
            r_segment_size <= scmt_pkg::RST_SEGMENT_SIZE;
            r_swap_size    <= scmt_pkg::RST_SWAP_SIZE;
        end else if (i_cfg_wr) begin
            case (i_cfg_index)
                scmt_pkg::CFG_MIN_CHUNK:    r_min_chunk    <= i_cfg_data[scmt_pkg::MIN_W-1:0];
                scmt_pkg::CFG_MAX_CHUNK:    r_max_chunk    <= i_cfg_data[scmt_pkg::MAX_W-1:0];
                scmt_pkg::CFG_SEGMENT_SIZE: r_segment_size <= i_cfg_data;
                scmt_pkg::CFG_SWAP_SIZE:    r_swap_size    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // chunk map: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture && i_op == scmt_pkg::OP_LOAD && wr_ok) begin
            map_mem[wr_addr] <= i_entry_block;
        end
        if (i_cmd.rd) begin
            r_rd_data <= map_mem[r_idx[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status <= scmt_pkg::ST_OK;
        end else if (i_cmd.capture) begin
            r_status <= scmt_pkg::ST_OK;
        end else if (i_cmd.seg_chk && o_sts.seg_err) begin
            r_status <= scmt_pkg::ST_SEG;
        end else if (i_cmd.map_err) begin
            r_status <= scmt_pkg::ST_MAP;
        end else if (i_cmd.bound && o_sts.swap_err) begin
            r_status <= scmt_pkg::ST_SWAP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op  <= i_op;
            r_rev <= i_reverse;
            r_off <= i_vs_offset;
            r_req <= i_request_size;
            r_blk <= first_blk;
            r_idx <= '0;
        end else if (i_cmd.walk_step) begin
            // advance one chunk; double until max_chunk is reached
            r_off <= r_off - BW'(r_blk);
            if (r_blk < CW'(r_max_chunk)) begin
                r_blk <= r_blk << 1;
            end
            r_idx <= r_idx + CNT_W'(1);
        end
        if (i_cmd.bound) begin
            r_run <= run_next;
        end
        if (i_cmd.delta) begin
            r_delta <= r_rev ? (BW'(r_blk) - (r_off + r_run)) : r_off;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_o_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_status <= r_status;
            r_o_base   <= res_ok ? (r_rd_data + r_delta) : '0;
            r_o_run    <= res_ok ? r_run : '0;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_disk_base = r_o_base;
    assign o_run_size  = r_o_run;
    assign o_status    = r_o_status;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_status != scmt_pkg::ST_OK) |-> (r_o_base == '0 && r_o_run == '0))
        else $error("scmt_dpath: error result with nonzero fields");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd |-> (r_off < BW'(r_blk)))
        else $error("scmt_dpath: map read before the walk settled");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.out_load && res_ok) |=> (r_o_run <= r_req && r_o_run != '0 || r_req == '0))
        else $error("scmt_dpath: run size exceeds request");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.out_load && r_op == scmt_pkg::OP_LOAD) |=>
        (r_o_base == '0 && r_o_run == '0 && r_o_status == scmt_pkg::ST_OK))
        else $error("scmt_dpath: load item result not zero");

endmodule

`default_nettype wire

// ===== hdl/swap_chunk_map_translate_top.sv =====
// ----------------------------------------------------------------------------
// swap_chunk_map_translate_top
// Swap chunk map translator: maps a segment offset and length to the
// largest contiguous physical run on the swap device.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_stall): op 0 loads map entry
// i_entry_index with i_entry_block, op 1 translates i_vs_offset and
// i_request_size, with i_reverse placing the run back from the chunk end.
// Every item gives exactly one result on the output channel
// (o_out_valid / i_out_stall): disk base, run size and status.
// One item is in flight at a time. A load goes from accept straight to
// the result. A translate checks the segment and walks the chunks (at
// most MAP_ENTRIES of them): the walk loop subtracts one chunk per
// cycle; then the map memory is read, and the bound check and run
// placement finish the item. Errors end the item early.
// A finished result sits in the output register; the block holds a new
// result until the receiver drops i_out_stall, and accepts the next item
// as soon as the result is registered.
// Configuration writes (i_cfg_valid / o_cfg_ready) are always taken;
// the user must issue them only while the block is idle, as the block
// itself has no check for it. Reset clears the control state and loads
// the register reset values; map entries are undefined until loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module swap_chunk_map_translate_top #(
    parameter int unsigned MAP_ENTRIES = 32
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // configuration write channel
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [scmt_pkg::CFGI_W-1:0]        i_cfg_index,
    input  wire logic [scmt_pkg::BLOCK_W-1:0]       i_cfg_data,
    // input item channel
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire logic                               i_op,
    input  wire logic [scmt_pkg::EIDX_W-1:0]        i_entry_index,
    input  wire logic [scmt_pkg::BLOCK_W-1:0]       i_entry_block,
    input  wire logic [scmt_pkg::BLOCK_W-1:0]       i_vs_offset,
    input  wire logic [scmt_pkg::BLOCK_W-1:0]       i_request_size,
    input  wire logic                               i_reverse,
    // result channel
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output logic [scmt_pkg::BLOCK_W-1:0]            o_disk_base,
    output logic [scmt_pkg::BLOCK_W-1:0]            o_run_size,
    output logic [1:0]                              o_status
);

    scmt_pkg::t_cmd cmd;
    scmt_pkg::t_sts sts;
    logic           cfg_wr;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    scmt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    scmt_dpath #(
        .MAP_ENTRIES (MAP_ENTRIES)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr       (cfg_wr),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_op           (i_op),
        .i_entry_index  (i_entry_index),
        .i_entry_block  (i_entry_block),
        .i_vs_offset    (i_vs_offset),
        .i_request_size (i_request_size),
        .i_reverse      (i_reverse),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_disk_base    (o_disk_base),
        .o_run_size     (o_run_size),
        .o_status       (o_status)
    );

endmodule

`default_nettype wire

// ===== tb/scmt_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scmt_checker
// Watches the configuration, input and result channels of the swap chunk
// map translator, predicts each result from its own copy of the registers
// and the chunk map, and compares every result field by field in order.
// ----------------------------------------------------------------------------

module scmt_checker #(
    parameter int unsigned MAP_ENTRIES = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    input  logic                                i_cfg_ready,
    input  logic [scmt_pkg::CFGI_W-1:0]         i_cfg_index,
    input  logic [scmt_pkg::BLOCK_W-1:0]        i_cfg_data,
    input  logic                                i_in_valid,
    input  logic                                i_in_stall,
    input  logic                                i_op,
    input  logic [scmt_pkg::EIDX_W-1:0]         i_entry_index,
    input  logic [scmt_pkg::BLOCK_W-1:0]        i_entry_block,
    input  logic [scmt_pkg::BLOCK_W-1:0]        i_vs_offset,
    input  logic [scmt_pkg::BLOCK_W-1:0]        i_request_size,
    input  logic                                i_reverse,
    input  logic                                i_out_valid,
    input  logic                                i_out_stall,
    input  logic [scmt_pkg::BLOCK_W-1:0]        i_disk_base,
    input  logic [scmt_pkg::BLOCK_W-1:0]        i_run_size,
    input  logic [1:0]                          i_status,
    output int                                  o_errors,
    output int                                  o_pending
);

    localparam int unsigned BLOCK_W = scmt_pkg::BLOCK_W;
    localparam int unsigned MIN_W   = scmt_pkg::MIN_W;
    localparam int unsigned MAX_W   = scmt_pkg::MAX_W;
    localparam int unsigned IDX_W   = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;

    typedef struct packed {
        logic [BLOCK_W-1:0] disk_base;
        logic [BLOCK_W-1:0] run_size;
        logic [1:0]         status;
    } t_disk_run;

    logic [MIN_W-1:0]   min_chunk_q;
    logic [MAX_W-1:0]   max_chunk_q;
    logic [BLOCK_W-1:0] segment_size_q;
    logic [BLOCK_W-1:0] swap_size_q;
    logic [BLOCK_W-1:0] chunk_base [MAP_ENTRIES];
    t_disk_run          expected_runs [$];

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end

    // Walk the doubling chunk sizes and place the run inside the chunk found.
    function automatic t_disk_run locate_run(logic [BLOCK_W-1:0] vs_off,
                                             logic [BLOCK_W-1:0] req_size,
                                             logic rev);
        t_disk_run   r;
        logic [31:0] off;
        logic [31:0] req;
        logic [31:0] chunk;
        logic [31:0] base;
        logic [31:0] span;
        logic [31:0] run;
        int unsigned walk;
        r     = '0;
        off   = {8'd0, vs_off};
        req   = {8'd0, req_size};
        if (off + req > {8'd0, segment_size_q}) begin
            r.status = scmt_pkg::ST_SEG;
            return r;
        end
        chunk = (min_chunk_q == '0) ? 32'd1 : {15'd0, min_chunk_q};
        walk  = 0;
        while (off >= chunk) begin
            off = off - chunk;
            if (chunk < {11'd0, max_chunk_q})
                chunk = chunk << 1;
            walk++;
            if (walk >= MAP_ENTRIES)
                break;
        end
        if (walk >= MAP_ENTRIES) begin
            r.status = scmt_pkg::ST_MAP;
            return r;
        end
        base = {8'd0, chunk_base[walk[IDX_W-1:0]]};
        if (base + chunk > {8'd0, swap_size_q}) begin
            r.status = scmt_pkg::ST_SWAP;
            return r;
        end
        span = chunk - off;
        run  = (req < span) ? req : span;
        base = rev ? base + chunk - (off + run) : base + off;
        r.disk_base = base[BLOCK_W-1:0];
        r.run_size  = run[BLOCK_W-1:0];
        r.status    = scmt_pkg::ST_OK;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_disk_run got;
        t_disk_run want;
        if (!i_rst_n) begin
            min_chunk_q    = scmt_pkg::RST_MIN_CHUNK;
            max_chunk_q    = scmt_pkg::RST_MAX_CHUNK;
            segment_size_q = scmt_pkg::RST_SEGMENT_SIZE;
            swap_size_q    = scmt_pkg::RST_SWAP_SIZE;
            expected_runs.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    scmt_pkg::CFG_MIN_CHUNK:    min_chunk_q    = i_cfg_data[MIN_W-1:0];
                    scmt_pkg::CFG_MAX_CHUNK:    max_chunk_q    = i_cfg_data[MAX_W-1:0];
                    scmt_pkg::CFG_SEGMENT_SIZE: segment_size_q = i_cfg_data;
                    scmt_pkg::CFG_SWAP_SIZE:    swap_size_q    = i_cfg_data;
                    default: ;
                endcase
            end
            // check results before taking new items in the same cycle
            if (i_out_valid && !i_out_stall) begin
                got = '{disk_base: i_disk_base, run_size: i_run_size, status: i_status};
                if (expected_runs.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10)
                        $display("%0t: result without a pending item: base %h run %h st %0d",
                                 $realtime, got.disk_base, got.run_size, got.status);
                end else begin
                    want = expected_runs.pop_front();
                    if (got.disk_base !== want.disk_base || got.run_size !== want.run_size
                            || got.status !== want.status) begin
                        o_errors++;
                        if (o_errors <= 10)
                            $display({"%0t: mismatch: base exp %h got %h, run exp %h got %h,",
                                      " status exp %0d got %0d"}, $realtime,
                                     want.disk_base, got.disk_base, want.run_size,
                                     got.run_size, want.status, got.status);
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_op == scmt_pkg::OP_LOAD) begin
                    if (i_entry_index < MAP_ENTRIES)
                        chunk_base[i_entry_index] = i_entry_block;
                    expected_runs.push_back('0);
                end else begin
                    expected_runs.push_back(locate_run(i_vs_offset, i_request_size, i_reverse));
                end
            end
        end
        o_pending = expected_runs.size();
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives the swap chunk map translator through several chunk geometries:
// loads the whole map, runs directed edge cases, then random loads and
// translations aimed at chunk edges, with random gaps and result stalls.
// ----------------------------------------------------------------------------

module tb;

    localparam int unsigned MAP_ENTRIES = 32;
    localparam int unsigned BLOCK_W     = scmt_pkg::BLOCK_W;
    localparam int unsigned EIDX_W      = scmt_pkg::EIDX_W;
    localparam int unsigned CFGI_W      = scmt_pkg::CFGI_W;

    logic                clk;
    logic                rst_n;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [CFGI_W-1:0]   cfg_index;
    logic [BLOCK_W-1:0]  cfg_data;
    logic                in_valid;
    logic                in_stall;
    logic                op;
    logic [EIDX_W-1:0]   entry_index;
    logic [BLOCK_W-1:0]  entry_block;
    logic [BLOCK_W-1:0]  vs_offset;
    logic [BLOCK_W-1:0]  request_size;
    logic                reverse_run;
    logic                out_valid;
    logic                out_stall;
    logic [BLOCK_W-1:0]  disk_base;
    logic [BLOCK_W-1:0]  run_size;
    logic [1:0]          status;
    int                  errors;
    int                  pending;

    // chunk geometry as last written, used to aim offsets at chunk edges
    longint unsigned     cur_min;
    longint unsigned     cur_max;
    bit                  burst;

    swap_chunk_map_translate_top #(.MAP_ENTRIES(MAP_ENTRIES)) dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_op           (op),
        .i_entry_index  (entry_index),
        .i_entry_block  (entry_block),
        .i_vs_offset    (vs_offset),
        .i_request_size (request_size),
        .i_reverse      (reverse_run),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_disk_base    (disk_base),
        .o_run_size     (run_size),
        .o_status       (status)
    );

    scmt_checker #(.MAP_ENTRIES(MAP_ENTRIES)) u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_valid    (cfg_valid),
        .i_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_op           (op),
        .i_entry_index  (entry_index),
        .i_entry_block  (entry_block),
        .i_vs_offset    (vs_offset),
        .i_request_size (request_size),
        .i_reverse      (reverse_run),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_disk_base    (disk_base),
        .i_run_size     (run_size),
        .i_status       (status),
        .o_errors       (errors),
        .o_pending      (pending)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial begin
        #10_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // mostly short gaps, a few long ones
    function automatic int idle_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 50)
            return 0;
        if (pick < 85)
            return $urandom_range(1, 3);
        if (pick < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // receiver: stall in bursts, with occasional long quiet stretches
    initial begin
        int quiet;
        int busy;
        out_stall = 1'b0;
        forever begin
            quiet = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                 : $urandom_range(0, 8);
            busy  = idle_len() + 1;
            repeat (quiet) @(negedge clk);
            @(negedge clk) out_stall <= 1'b1;
            repeat (busy) @(negedge clk);
            out_stall <= 1'b0;
        end
    end

    // start block of chunk idx and its size under the current geometry
    function automatic longint unsigned chunk_origin(int idx, output longint unsigned size);
        longint unsigned start;
        longint unsigned blk;
        start = 0;
        blk   = (cur_min == 0) ? 1 : cur_min;
        for (int k = 0; k < idx; k++) begin
            start += blk;
            if (blk < cur_max)
                blk = blk * 2;
        end
        size = blk;
        return start;
    endfunction

    task automatic send_item(logic item_op, logic [EIDX_W-1:0] idx, logic [BLOCK_W-1:0] blk,
                             logic [BLOCK_W-1:0] off, logic [BLOCK_W-1:0] req, logic rev);
        int gap;
        gap = burst ? 0 : idle_len();
        if (gap > 0) begin
            @(negedge clk) in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid     <= 1'b1;
        op           <= item_op;
        entry_index  <= idx;
        entry_block  <= blk;
        vs_offset    <= off;
        request_size <= req;
        reverse_run  <= rev;
        do @(posedge clk); while (in_stall);
    endtask

    // unused fields carry random values so that every bit toggles
    task automatic load_entry(logic [EIDX_W-1:0] idx, logic [BLOCK_W-1:0] blk);
        send_item(scmt_pkg::OP_LOAD, idx, blk, BLOCK_W'($urandom), BLOCK_W'($urandom),
                  1'($urandom));
    endtask

    task automatic translate(logic [BLOCK_W-1:0] off, logic [BLOCK_W-1:0] req, logic rev);
        send_item(scmt_pkg::OP_XLATE, EIDX_W'($urandom), BLOCK_W'($urandom), off, req, rev);
    endtask

    // hold the sender until every result is back
    task automatic drain();
        @(negedge clk) in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFGI_W-1:0] idx, longint unsigned value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= BLOCK_W'(value);
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic random_items(int count);
        int              pick;
        int              idx;
        longint unsigned start;
        longint unsigned size;
        longint unsigned pos;
        longint unsigned req;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
                load_entry(EIDX_W'($urandom_range(0, MAP_ENTRIES - 1)),
                           ($urandom_range(0, 4) == 0)
                               ? BLOCK_W'($urandom)
                               : BLOCK_W'($urandom_range(0, 24'h3FFFFF)));
            end else if (pick < 25) begin
                translate(BLOCK_W'($urandom),
                          ($urandom_range(0, 1) == 1) ? BLOCK_W'($urandom)
                                                      : BLOCK_W'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)));
            end else begin
                idx   = ($urandom_range(0, 19) == 0) ? MAP_ENTRIES
                                                     : $urandom_range(0, MAP_ENTRIES - 1);
                start = chunk_origin(idx, size);
                case ($urandom_range(0, 3))
                    0: pos = 0;
                    1: pos = size - 1;
                    default: pos = 64'($urandom_range(0, int'(size - 1)));
                endcase
                case ($urandom_range(0, 5))
                    0: req = 0;
                    1: req = 1;
                    2: req = size - pos;
                    3: req = size - pos + 1 + 64'($urandom_range(0, 15));
                    4: req = 64'($urandom_range(0, 63));
                    default: req = 64'($urandom_range(0, int'(2 * size)));
                endcase
                if (req > 24'hFFFFFF)
                    req = 24'hFFFFFF;
                if (start + pos > 24'hFFFFFF)
                    translate(BLOCK_W'($urandom), BLOCK_W'(req), 1'($urandom_range(0, 1)));
                else
                    translate(BLOCK_W'(start + pos), BLOCK_W'(req), 1'($urandom_range(0, 1)));
            end
        end
    endtask

    // settle, reprogram the geometry, then run random items
    task automatic run_phase(longint unsigned min_c, longint unsigned max_c,
                             longint unsigned seg, longint unsigned swap_blocks, int count);
        drain();
        cur_min = min_c;
        cur_max = max_c;
        write_reg(scmt_pkg::CFG_MIN_CHUNK, min_c);
        write_reg(scmt_pkg::CFG_MAX_CHUNK, max_c);
        write_reg(scmt_pkg::CFG_SEGMENT_SIZE, seg);
        write_reg(scmt_pkg::CFG_SWAP_SIZE, swap_blocks);
        @(negedge clk) cfg_valid <= 1'b0;
        burst = ($urandom_range(0, 3) == 0);
        random_items(count);
    endtask

    initial begin
        longint unsigned st;
        longint unsigned sz;
        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = scmt_pkg::CFG_MIN_CHUNK;
        cfg_data     = '0;
        in_valid     = 1'b0;
        op           = scmt_pkg::OP_LOAD;
        entry_index  = '0;
        entry_block  = '0;
        vs_offset    = '0;
        request_size = '0;
        reverse_run  = 1'b0;
        burst        = 1'b0;
        cur_min      = 64'(scmt_pkg::RST_MIN_CHUNK);
        cur_max      = 64'(scmt_pkg::RST_MAX_CHUNK);
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        // fill the whole map so that no translation reads an unloaded entry
        for (int i = 0; i < MAP_ENTRIES; i++) begin
            if (i == 0)
                load_entry(EIDX_W'(i), '0);
            else if (i == MAP_ENTRIES - 1)
                load_entry(EIDX_W'(i), 24'hFFFFFF);
            else
                load_entry(EIDX_W'(i), BLOCK_W'($urandom_range(0, 24'h3FFFFF)));
        end

        // reset geometry: empty segment and no swap space
        translate(0, 0, 0);
        translate(1, 0, 1);

        run_phase(32, 1024, 24'hFFFFFF, 24'hFFFFFF, 0);
        translate(0, 0, 0);
        translate(0, 1, 1);
        translate(31, 100, 0);
        translate(0, 24'hFFFFFF, 1);
        translate(24'hFFFFFF, 24'hFFFFFF, 0);
        translate(24'hFFFFFF, 0, 1);
        // last map entry, then the first block past the map
        load_entry(EIDX_W'(MAP_ENTRIES - 1), 24'h000100);
        st = chunk_origin(MAP_ENTRIES - 1, sz);
        translate(BLOCK_W'(st + sz - 1), 1, 1);
        translate(BLOCK_W'(st + sz), 1, 0);
        // entry whose chunk runs off the end of the device
        load_entry(7, 24'hFFFFFF);
        st = chunk_origin(7, sz);
        translate(BLOCK_W'(st), 1, 0);
        load_entry(7, 24'h123456);
        translate(BLOCK_W'(st + 5), BLOCK_W'(sz), 1);
        random_items(150);

        // zero first chunk acts as one block; max of one stops doubling
        run_phase(0, 1, 40, 24'hFFFFFF, 120);
        run_phase(65536, 1048576, 24'hFFFFFF, 24'hFFFFFF, 150);
        run_phase(65536, 1, 24'hFFFFFF, 24'h400000, 120);
        run_phase(1, 1048576, 24'h100000, 0, 40);
        run_phase(3, 48, 2000, 24'h300000, 150);
        run_phase(1000, 1000, 24'h8000, 24'h500000, 120);
        run_phase(32, 1024, 0, 24'hFFFFFF, 50);
        for (int p = 0; p < 3; p++)
            run_phase(64'($urandom_range(1, 65536)), 64'($urandom_range(1, 1048576)),
                      64'($urandom_range(0, 24'hFFFFFF)), 64'($urandom_range(0, 24'hFFFFFF)),
                      80);

        @(negedge clk) in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== swap_chunk_map_translate_top.f =====
hdl/scmt_pkg.sv
hdl/scmt_ctrl.sv
hdl/scmt_dpath.sv
hdl/swap_chunk_map_translate_top.sv
tb/scmt_checker.sv
tb/tb.sv
